// ----- hdl/button_click_classifier_core_macros.svh -----
// ----------------------------------------------------------------------------
// Button click classifier - assertion macros
// Clocked assertion helpers shared by the RTL; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, ignored while reset is applied
`define BCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("button classifier check failed");

// Check a property on every rising edge, reset included
`define BCC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("button classifier check failed");

`else

`define BCC_ASSERT(label, clk, rst_n, prop)
`define BCC_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hdl/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Button click classifier - package
// Widths, register indexes, reset values, phase and event codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    // Field widths
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int EVENT_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN   = 2'd2;

    // Configuration reset values
    localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 16'd10;
    localparam logic [TIME_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [TIME_W-1:0] DOUBLE_WIN_RST = 16'd500;

    // Press/release phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_DEB_PRESS  = 8'b0000_0010,
        PH_PRESSED    = 8'b0000_0100,
        PH_DEB_REL    = 8'b0000_1000,
        PH_WAIT2      = 8'b0001_0000,
        PH_DEB_PRESS2 = 8'b0010_0000,
        PH_PRESSED2   = 8'b0100_0000,
        PH_DEB_REL2   = 8'b1000_0000
    } phase_t;

    // Click events
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } click_event_t;

endpackage

`default_nettype wire

// ----- hdl/button_click_classifier_core.sv -----
// ----------------------------------------------------------------------------
// Button click classifier - core
// Debounces button samples and reports short, double and long presses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Each input item is one button sample (level plus milliseconds since the
// previous sample) and gives exactly one result item: none, short, double
// or long. The phase update is a saturating add and a few compares done in
// the accepting cycle, so one item is taken every clock cycle unless a result
// is stalled, and its result appears in the output register on the next cycle.
// The output register passes ready through, so a new item is accepted while the
// previous result is being taken; input ready drops only while an unread result
// is stalled. Configuration writes land on the clock edge with the write enable
// high and take effect from the next item; indexes beyond the last register are
// ignored.
module button_click_classifier_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bcc_pkg::TIME_W-1:0]       cfg_wdata,
    // Sample input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_btn_down,
    input  wire logic [bcc_pkg::ELAPSED_W-1:0]    s_elapsed_ms,
    // Event output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [bcc_pkg::EVENT_W-1:0]           m_click_event
);

    import bcc_pkg::*;

`include "button_click_classifier_core_macros.svh"

    // Configuration registers
    logic [TIME_W-1:0] debounce_ms_reg;
    logic [TIME_W-1:0] long_press_ms_reg;
    logic [TIME_W-1:0] double_window_ms_reg;

    // Classifier state
    phase_t            phase_reg, phase_next;
    logic [TIME_W-1:0] since_mark_reg, since_mark_next;
    logic [TIME_W-1:0] first_press_reg, first_press_next;
    logic [TIME_W-1:0] second_press_reg, second_press_next;

    // Result register
    logic              m_valid_reg;
    click_event_t      m_event_reg;
    click_event_t      event_next;

    logic              in_acc;
    logic [TIME_W:0]   time_sum;
    logic [TIME_W-1:0] time_sat;

    // Accept while the result register is empty or being drained
    assign s_ready       = !m_valid_reg || m_ready;
    assign in_acc        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_click_event = m_event_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg      <= DEBOUNCE_RST;
            long_press_ms_reg    <= LONG_PRESS_RST;
            double_window_ms_reg <= DOUBLE_WIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   debounce_ms_reg      <= cfg_wdata;
                CFG_LONG_PRESS: long_press_ms_reg    <= cfg_wdata;
                CFG_DOUBLE_WIN: double_window_ms_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the time since the last mark, saturating at full scale
    assign time_sum = {1'b0, since_mark_reg}
                    + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, s_elapsed_ms};
    assign time_sat = time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];

    // Phase update for one sample
    always_comb begin
        phase_next        = phase_reg;
        since_mark_next   = time_sat;
        first_press_next  = first_press_reg;
        second_press_next = second_press_reg;
        event_next        = EV_NONE;
        unique case (phase_reg)
            PH_IDLE: begin
                if (s_btn_down) begin
                    phase_next      = PH_DEB_PRESS;
                    since_mark_next = '0;
                end
            end
            PH_DEB_PRESS: begin
                if (!s_btn_down) begin
                    phase_next = PH_IDLE;
                end else if (time_sat >= debounce_ms_reg) begin
                    phase_next      = PH_PRESSED;
                    since_mark_next = '0;
                end
            end
            PH_PRESSED: begin
                if (!s_btn_down) begin
                    first_press_next = time_sat;
                    phase_next       = PH_DEB_REL;
                    since_mark_next  = '0;
                end
            end
            PH_DEB_REL: begin
                // A press here is a release bounce: keep the running mark
                if (s_btn_down) begin
                    phase_next = PH_PRESSED;
                end else if (time_sat >= debounce_ms_reg) begin
                    if (first_press_reg >= long_press_ms_reg) begin
                        phase_next = PH_IDLE;
                        event_next = EV_LONG;
                    end else begin
                        phase_next      = PH_WAIT2;
                        since_mark_next = '0;
                    end
                end
            end
            PH_WAIT2: begin
                if (s_btn_down) begin
                    phase_next      = PH_DEB_PRESS2;
                    since_mark_next = '0;
                end else if (time_sat >= double_window_ms_reg) begin
                    phase_next = PH_IDLE;
                    event_next = EV_SHORT;
                end
            end
            PH_DEB_PRESS2: begin
                // A release here is a press bounce: back to the window
                if (!s_btn_down) begin
                    phase_next = PH_WAIT2;
                end else if (time_sat >= debounce_ms_reg) begin
                    phase_next      = PH_PRESSED2;
                    since_mark_next = '0;
                end
            end
            PH_PRESSED2: begin
                if (!s_btn_down) begin
                    second_press_next = time_sat;
                    phase_next        = PH_DEB_REL2;
                    since_mark_next   = '0;
                end
            end
            PH_DEB_REL2: begin
                if (s_btn_down) begin
                    phase_next = PH_PRESSED2;
                end else if (time_sat >= debounce_ms_reg) begin
                    phase_next = PH_IDLE;
                    event_next = (second_press_reg >= long_press_ms_reg) ? EV_LONG
                                                                         : EV_DOUBLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Commit the state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            since_mark_reg   <= '0;
            first_press_reg  <= '0;
            second_press_reg <= '0;
        end else if (in_acc) begin
            phase_reg        <= phase_next;
            since_mark_reg   <= since_mark_next;
            first_press_reg  <= first_press_next;
            second_press_reg <= second_press_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            m_event_reg <= event_next;
        end
    end

    // Any reported click ends the sequence
    `BCC_ASSERT(a_event_ends_in_idle, aclk, aresetn,
        (in_acc && event_next != EV_NONE) |=> (phase_reg == PH_IDLE))
    // A double can only come out of the second release debounce
    `BCC_ASSERT(a_double_from_rel2, aclk, aresetn,
        (in_acc && event_next == EV_DOUBLE) |-> (phase_reg == PH_DEB_REL2))
    // Time only moves when an item is taken
    `BCC_ASSERT(a_time_holds_idle, aclk, aresetn,
        !in_acc |=> $stable(since_mark_reg))
    // Input back-pressure only comes from a stalled result
    `BCC_ASSERT_ALWAYS(a_ready_only_stalled, aclk,
        !s_ready |-> (m_valid_reg && !m_ready))

endmodule

`default_nettype wire

// ----- verif/button_click_classifier_core_test.sv -----
// ----------------------------------------------------------------------------
// Button click classifier - core testbench
// Feeds button samples through the classifier and compares every event with
// a cycle-free model of the press/release phases. A short directed run is
// followed by random press gestures under several register settings, with
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_classifier_core_test;

    import bcc_pkg::*;

    // Unused register index: writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 240;

    // ------------------------------------------------------------------------
    // Event scoreboard: predicts the event of each accepted sample
    // ------------------------------------------------------------------------
    class click_scoreboard;
        logic [TIME_W-1:0] debounce_ms;
        logic [TIME_W-1:0] long_press_ms;
        logic [TIME_W-1:0] double_window_ms;
        phase_t            phase;
        logic [TIME_W-1:0] since_mark_ms;
        logic [TIME_W-1:0] first_len_ms;
        logic [TIME_W-1:0] second_len_ms;
        click_event_t      expected_events[$];
        int                mismatches;
        int                event_tally[4];

        function new();
            debounce_ms      = DEBOUNCE_RST;
            long_press_ms    = LONG_PRESS_RST;
            double_window_ms = DOUBLE_WIN_RST;
            phase            = PH_IDLE;
            since_mark_ms    = '0;
            first_len_ms     = '0;
            second_len_ms    = '0;
            mismatches       = 0;
            foreach (event_tally[i]) event_tally[i] = 0;
        endfunction

        function void set_config(logic [TIME_W-1:0] db, logic [TIME_W-1:0] lp,
                                 logic [TIME_W-1:0] dw);
            debounce_ms      = db;
            long_press_ms    = lp;
            double_window_ms = dw;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Advance the phase machine by one sample and return its event
        function click_event_t classify_sample(bit down, logic [ELAPSED_W-1:0] el);
            logic [TIME_W:0] sum;
            click_event_t    ev;
            sum = {1'b0, since_mark_ms} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, el};
            since_mark_ms = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            ev = EV_NONE;
            case (phase)
                PH_IDLE: begin
                    if (down) begin
                        phase = PH_DEB_PRESS;
                        since_mark_ms = '0;
                    end
                end
                PH_DEB_PRESS: begin
                    if (!down) begin
                        phase = PH_IDLE;
                    end else if (since_mark_ms >= debounce_ms) begin
                        phase = PH_PRESSED;
                        since_mark_ms = '0;
                    end
                end
                PH_PRESSED: begin
                    if (!down) begin
                        first_len_ms = since_mark_ms;
                        phase = PH_DEB_REL;
                        since_mark_ms = '0;
                    end
                end
                PH_DEB_REL: begin
                    if (down) begin
                        phase = PH_PRESSED;
                    end else if (since_mark_ms >= debounce_ms) begin
                        if (first_len_ms >= long_press_ms) begin
                            phase = PH_IDLE;
                            ev = EV_LONG;
                        end else begin
                            phase = PH_WAIT2;
                            since_mark_ms = '0;
                        end
                    end
                end
                PH_WAIT2: begin
                    if (down) begin
                        phase = PH_DEB_PRESS2;
                        since_mark_ms = '0;
                    end else if (since_mark_ms >= double_window_ms) begin
                        phase = PH_IDLE;
                        ev = EV_SHORT;
                    end
                end
                PH_DEB_PRESS2: begin
                    if (!down) begin
                        phase = PH_WAIT2;
                    end else if (since_mark_ms >= debounce_ms) begin
                        phase = PH_PRESSED2;
                        since_mark_ms = '0;
                    end
                end
                PH_PRESSED2: begin
                    if (!down) begin
                        second_len_ms = since_mark_ms;
                        phase = PH_DEB_REL2;
                        since_mark_ms = '0;
                    end
                end
                default: begin
                    if (down) begin
                        phase = PH_PRESSED2;
                    end else if (since_mark_ms >= debounce_ms) begin
                        phase = PH_IDLE;
                        ev = (second_len_ms >= long_press_ms) ? EV_LONG : EV_DOUBLE;
                    end
                end
            endcase
            return ev;
        endfunction

        function void note_sample(bit down, logic [ELAPSED_W-1:0] el);
            expected_events.push_back(classify_sample(down, el));
        endfunction

        task check_event(logic [EVENT_W-1:0] got);
            click_event_t want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event %0d with no sample outstanding", got));
            end else begin
                want = expected_events.pop_front();
                event_tally[want]++;
                if (got !== want)
                    report_mismatch($sformatf("click_event %0d, expected %0d (%s)",
                                              got, want, want.name()));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_DEBOUNCE;
    logic [TIME_W-1:0]    cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_btn_down    = 1'b0;
    logic [ELAPSED_W-1:0] s_elapsed_ms  = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [EVENT_W-1:0]   m_click_event;

    click_scoreboard sb;
    bit              stalls_on = 1'b1;
    int              items_sent = 0;
    int              settings_run = 1;
    int              quiet_cycles = 0;

    button_click_classifier_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_btn_down    (s_btn_down),
        .s_elapsed_ms  (s_elapsed_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_click_event (m_click_event)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Randomly hold off the event channel
    always @(posedge aclk) begin
        m_ready <= !(stalls_on && $urandom_range(99) < 12);
    end

    // Note accepted samples, then check accepted events
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_btn_down, s_elapsed_ms);
            if (m_valid && m_ready) sb.check_event(m_click_event);
        end
    end

    // Watchdog: give up when no item moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample, with an occasional idle gap in front
    task automatic send_sample(input bit down, input logic [ELAPSED_W-1:0] el);
        if (stalls_on && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 12);
        end
        s_valid      <= 1'b1;
        s_btn_down   <= down;
        s_elapsed_ms <= el;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid and wait until every event has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all registers, plus the unused index, on consecutive edges
    task automatic write_config(input logic [TIME_W-1:0] db, input logic [TIME_W-1:0] lp,
                                input logic [TIME_W-1:0] dw);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_wdata <= db;
        @(posedge aclk);
        cfg_index <= CFG_LONG_PRESS;
        cfg_wdata <= lp;
        @(posedge aclk);
        cfg_index <= CFG_DOUBLE_WIN;
        cfg_wdata <= dw;
        @(posedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_wdata <= TIME_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_config(db, lp, dw);
        settings_run++;
    endtask

    function automatic int unsigned pick_below(int unsigned x);
        return (x == 0) ? 0 : $urandom_range(x - 1, 0);
    endfunction

    // Hold one level for at least dur_ms, in random steps, with rare chatter
    task automatic hold_level(input bit lvl, input int unsigned dur_ms);
        int unsigned acc;
        int unsigned step_max;
        int unsigned el;
        acc = 0;
        step_max = dur_ms / 4 + 1;
        if (step_max > 4095) step_max = 4095;
        do begin
            el = $urandom_range(step_max, 0);
            if ($urandom_range(99) < 4)
                send_sample(!lvl, el[ELAPSED_W-1:0]);
            else
                send_sample(lvl, el[ELAPSED_W-1:0]);
            acc += el;
        end while (acc < dur_ms);
    endtask

    // One random gesture shaped around the current thresholds
    task automatic run_gesture();
        int unsigned db;
        int unsigned lp;
        int unsigned dw;
        int unsigned kind;
        db = sb.debounce_ms;
        lp = sb.long_press_ms;
        dw = sb.double_window_ms;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3: begin
                // single short click, then let the window expire
                hold_level(1'b1, db + pick_below(lp));
                hold_level(1'b0, db + dw + $urandom_range(50));
            end
            4, 5, 6: begin
                // double click, second press short or long
                hold_level(1'b1, db + pick_below(lp));
                hold_level(1'b0, db + pick_below(dw));
                if ($urandom_range(1))
                    hold_level(1'b1, db + pick_below(lp));
                else
                    hold_level(1'b1, db + lp + $urandom_range(200));
                hold_level(1'b0, db + $urandom_range(20));
            end
            7: begin
                // long press
                hold_level(1'b1, db + lp + $urandom_range(200));
                hold_level(1'b0, db + $urandom_range(20));
            end
            8: begin
                // unshaped noise over the whole field range
                repeat ($urandom_range(8, 1))
                    send_sample(1'($urandom_range(1)), ELAPSED_W'($urandom_range(4095)));
            end
            default: begin
                // contact chatter around the debounce time
                repeat ($urandom_range(10, 2))
                    send_sample(1'($urandom_range(1)),
                                ELAPSED_W'($urandom_range(db + 2, 0)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_end;
        sb = new();

        // Reset
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset thresholds: short click with full window wait
        send_sample(1'b1, 12'd0);
        send_sample(1'b1, 12'd12);
        send_sample(1'b1, 12'd300);
        send_sample(1'b0, 12'd0);
        send_sample(1'b0, 12'd10);
        send_sample(1'b0, 12'hFFF);
        // Press bounce, then a release bounce on the first press
        send_sample(1'b1, 12'd3);
        send_sample(1'b0, 12'd2);
        send_sample(1'b1, 12'd0);
        send_sample(1'b1, 12'd10);
        send_sample(1'b1, 12'd100);
        send_sample(1'b0, 12'd1);
        send_sample(1'b1, 12'd1);
        send_sample(1'b0, 12'd50);
        send_sample(1'b0, 12'd20);
        // Second press bounce, then a long second press
        send_sample(1'b1, 12'd100);
        send_sample(1'b0, 12'd5);
        send_sample(1'b1, 12'd7);
        send_sample(1'b1, 12'd10);
        send_sample(1'b1, 12'hFFF);
        send_sample(1'b0, 12'd0);
        send_sample(1'b0, 12'd10);
        // Long first press
        send_sample(1'b1, 12'd0);
        send_sample(1'b1, 12'hFFF);
        send_sample(1'b1, 12'hFFF);
        send_sample(1'b0, 12'hFFF);
        send_sample(1'b0, 12'hFFF);

        // Random gestures under a sequence of register settings
        for (int p = 0; p < 8; p++) begin
            if (p != 0) begin
                drain();
                case (p)
                    1: write_config(16'd0, 16'd0, 16'd0);
                    2: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
                    3: write_config(DEBOUNCE_RST, LONG_PRESS_RST, DOUBLE_WIN_RST);
                    7: write_config(TIME_W'($urandom_range(40)), 16'd0, 16'hFFFF);
                    default: write_config(TIME_W'($urandom_range(40)),
                                          TIME_W'($urandom_range(2000, 20)),
                                          TIME_W'($urandom_range(800, 10)));
                endcase
            end
            // no idling on either side for one whole setting
            stalls_on = (p != 3);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) run_gesture();
        end

        // Wait out the last events
        drain();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d events never arrived", sb.pending()));

        $display("Ran %0d button samples across %0d threshold settings (zero to full scale)",
                 items_sent, settings_run);
        $display("Events checked: %0d none, %0d short, %0d double, %0d long",
                 sb.event_tally[EV_NONE], sb.event_tally[EV_SHORT],
                 sb.event_tally[EV_DOUBLE], sb.event_tally[EV_LONG]);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
